// ===== hw/rtl/planar_tile_row_to_rgb_macros.svh =====
// Assertion macros shared by the checker of the planar tile row decoder.
`ifndef PLANAR_TILE_ROW_TO_RGB_MACROS_SVH
`define PLANAR_TILE_ROW_TO_RGB_MACROS_SVH

// Concurrent assertion sampled on clk_i and switched off while rst_ni is low.
`define PTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define PTR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ptr_pkg.sv =====
// Constants, types and helper functions of the planar tile row decoder.
`timescale 1ns / 1ps
`default_nettype none

package ptr_pkg;

  // Image geometry and palette size.
  localparam int TilesPerRow = 16;
  localparam int MaxTileRows = 64;
  localparam int PalDepth    = 256;

  // Derived widths.
  localparam int ColW     = $clog2(TilesPerRow);
  localparam int RowShift = ColW + 3;
  localparam int RowCntW  = $clog2(MaxTileRows * 8 * TilesPerRow + 1);
  localparam int TileRowW = RowCntW - RowShift;
  localparam int PalIdxW  = $clog2(PalDepth);
  localparam int HeightW  = 7;
  localparam int BaseW    = 8;
  localparam int PixXW    = 7;
  localparam int PixYW    = 9;
  localparam int RgbW     = 24;

  // Opcodes of the input channel; code 3 carries no operation.
  typedef enum logic [1:0] {
    OpWritePal = 2'd0,
    OpRestart  = 2'd1,
    OpDecode   = 2'd2
  } opcode_e;

  // Register indexes of the configuration port.
  localparam logic RegPaletteBase = 1'b0;
  localparam logic RegHeight      = 1'b1;

  // Colour index of pixel k: bit 7-k of each plane, plane 0 as the LSB.
  function automatic logic [3:0] colour_index(input logic [7:0] p0, input logic [7:0] p1,
                                              input logic [7:0] p2, input logic [7:0] p3,
                                              input logic [2:0] k);
    logic [2:0] sh;
    sh = 3'd7 - k;
    return {p3[sh], p2[sh], p1[sh], p0[sh]};
  endfunction

  // Height register with zero treated as one and large values clamped.
  function automatic logic [HeightW-1:0] effective_height(input logic [HeightW-1:0] h);
    logic [HeightW-1:0] r;
    r = h;
    if (h == '0) r = HeightW'(1);
    else if (h > HeightW'(MaxTileRows)) r = HeightW'(MaxTileRows);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/planar_tile_row_to_rgb.sv =====
// Top level of the planar 4bpp tile row decoder with palette lookup.
// Timing: an accepted decode loads the row registers, and each pixel then passes through the
//   output register; a row's eight pixels follow on consecutive cycles if not stalled.
// Palette reads: the single read port of the palette RAM does one lookup per pixel, and the
//   next row is taken as the last pixel is read; palette writes and restarts wait while a row runs.
// Reset: asynchronous, active low; clears the row counter, the registers and the pipeline.
//   The palette RAM is not cleared and holds undefined data until written.
`timescale 1ns / 1ps
`default_nettype none

module planar_tile_row_to_rgb (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [23:0] entry_rgb_i,
  input  wire logic [7:0]  plane0_i,
  input  wire logic [7:0]  plane1_i,
  input  wire logic [7:0]  plane2_i,
  input  wire logic [7:0]  plane3_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       pixel_x_o,
  output logic [8:0]       pixel_y_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             last_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase of the port;
  // the port never inserts wait states.
  // ---------------------------------------------------------------------------
  logic [ptr_pkg::BaseW-1:0]   pal_base_q;
  logic [ptr_pkg::HeightW-1:0] height_q;
  logic                        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_base_q <= '0;
      height_q   <= ptr_pkg::HeightW'(1);
    end else if (cfg_we) begin
      case (paddr[2])
        ptr_pkg::RegPaletteBase: pal_base_q <= pwdata[ptr_pkg::BaseW-1:0];
        ptr_pkg::RegHeight:      height_q   <= pwdata[ptr_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      ptr_pkg::RegPaletteBase: prdata = 32'(pal_base_q);
      ptr_pkg::RegHeight:      prdata = 32'(height_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Row being expanded. A decode transaction loads the four plane bytes and the
  // tile coordinates; a pixel counter then walks the eight pixels, issuing one
  // palette read per cycle unless stalled. The next input transaction is taken
  // in the same cycle as the last pixel read, so rows follow without a gap.
  // ---------------------------------------------------------------------------
  logic                         cur_valid_q;
  logic [2:0]                   pix_q;
  logic [7:0]                   p0_q, p1_q, p2_q, p3_q;
  logic [ptr_pkg::ColW-1:0]     col_q;
  logic [ptr_pkg::PixYW-1:0]    y_q;
  logic [ptr_pkg::RowCntW-1:0]  row_cnt_q;

  logic                         in_acc;
  logic                         advance;
  logic                         row_done;
  logic                         is_decode;
  logic                         in_image;
  logic [ptr_pkg::TileRowW-1:0] tile_row;
  logic [ptr_pkg::HeightW-1:0]  eff_height;
  logic                         start_row;

  // A pixel moves on when the output register is empty or being emptied.
  assign advance    = cur_valid_q && (!out_valid_o || out_ready_i);
  assign row_done   = advance && (pix_q == 3'd7);
  assign in_ready_o = !cur_valid_q || row_done;
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_decode  = (opcode_i == ptr_pkg::OpDecode);
  assign tile_row   = row_cnt_q[ptr_pkg::RowCntW-1:ptr_pkg::RowShift];
  assign eff_height = ptr_pkg::effective_height(height_q);
  // Rows at or beyond the image height are dropped without advancing the counter.
  assign in_image   = ptr_pkg::RowCntW'(tile_row) < ptr_pkg::RowCntW'(eff_height);
  assign start_row  = in_acc && is_decode && in_image;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pix_q       <= '0;
      row_cnt_q   <= '0;
    end else begin
      if (start_row) begin
        cur_valid_q <= 1'b1;
        pix_q       <= '0;
      end else if (row_done) begin
        cur_valid_q <= 1'b0;
      end else if (advance) begin
        pix_q <= pix_q + 3'd1;
      end

      if (in_acc && (opcode_i == ptr_pkg::OpRestart)) begin
        row_cnt_q <= '0;
      end else if (start_row) begin
        row_cnt_q <= row_cnt_q + ptr_pkg::RowCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_row) begin
      p0_q  <= plane0_i;
      p1_q  <= plane1_i;
      p2_q  <= plane2_i;
      p3_q  <= plane3_i;
      col_q <= row_cnt_q[ptr_pkg::RowShift-1:3];
      // Tile row times eight plus the row within the tile, masked to the port width.
      y_q   <= ptr_pkg::PixYW'({tile_row, row_cnt_q[2:0]});
    end
  end

  // ---------------------------------------------------------------------------
  // Palette RAM: one write port driven by palette-write transactions, one read
  // port with a registered output that doubles as the colour half of the output
  // register. A write accepted in the cycle of a row's last read does not reach
  // that read, which returns the stored word from before the write.
  // ---------------------------------------------------------------------------
  logic [ptr_pkg::RgbW-1:0]    pal_mem [ptr_pkg::PalDepth];
  logic                        pal_we;
  logic [ptr_pkg::PalIdxW-1:0] pal_raddr;
  logic [ptr_pkg::BaseW-1:0]   idx_sum;
  logic [ptr_pkg::RgbW-1:0]    rgb_q;

  assign pal_we = in_acc && (opcode_i == ptr_pkg::OpWritePal)
                  && ({1'b0, entry_index_i} < 9'(ptr_pkg::PalDepth));

  // Base plus colour index wraps at eight bits, then at the palette depth.
  assign idx_sum   = pal_base_q + ptr_pkg::BaseW'(ptr_pkg::colour_index(p0_q, p1_q, p2_q,
                                                                        p3_q, pix_q));
  assign pal_raddr = idx_sum[ptr_pkg::PalIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[entry_index_i[ptr_pkg::PalIdxW-1:0]] <= entry_rgb_i;
    end
    if (advance) begin
      rgb_q <= pal_mem[pal_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: coordinates and the end-of-row flag load together with the
  // palette read, so all fields of a pixel appear in the same cycle.
  // ---------------------------------------------------------------------------
  logic                      out_valid_q;
  logic [ptr_pkg::PixXW-1:0] px_x_q;
  logic [ptr_pkg::PixYW-1:0] px_y_q;
  logic                      last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      px_x_q <= ptr_pkg::PixXW'({col_q, pix_q});
      px_y_q <= y_q;
      last_q <= (pix_q == 3'd7);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_x_q;
  assign pixel_y_o   = px_y_q;
  assign red_o       = rgb_q[23:16];
  assign green_o     = rgb_q[15:8];
  assign blue_o      = rgb_q[7:0];
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ptr_checker.sv =====
// Port-level checker of the planar tile row decoder and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "planar_tile_row_to_rgb_macros.svh"

module ptr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [6:0] pixel_x_o,
  input wire logic [8:0] pixel_y_o,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o,
  input wire logic       last_o
);

  // A stalled pixel keeps its valid and its whole payload.
  `PTR_ASSERT(a_out_hold,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pixel_x_o)
      && $stable(pixel_y_o) && $stable(red_o) && $stable(green_o) && $stable(blue_o)
      && $stable(last_o)),
    "stalled output transaction changed")

  // The end-of-row flag marks exactly the rightmost pixel of a tile.
  `PTR_ASSERT(a_last_pos,
    out_valid_o |-> (last_o == (pixel_x_o[2:0] == 3'd7)),
    "last flag does not match pixel position")

  // Pixels of one row follow back to back, stepping right on the same line.
  `PTR_ASSERT(a_row_burst,
    (out_valid_o && out_ready_i && !last_o) |=> (out_valid_o
      && (pixel_x_o == $past(pixel_x_o) + 7'd1) && (pixel_y_o == $past(pixel_y_o))),
    "pixel sequence within a row broken")

  // Once reset has been seen low at an edge, no output is valid at the next edge.
  `PTR_ASSERT_ALWAYS(a_reset_quiet,
    !rst_ni |=> !out_valid_o,
    "output valid during reset")

endmodule

bind planar_tile_row_to_rgb ptr_checker u_ptr_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the planar 4bpp tile row decoder with palette lookup.
`timescale 1ns / 1ps

module tb;

  // Opcode 3 has no member in the package enum; the block must ignore it.
  localparam logic [1:0] OpUnused = 2'd3;

  // Byte addresses of the two configuration registers.
  localparam logic [2:0] AddrBase   = {ptr_pkg::RegPaletteBase, 2'b00};
  localparam logic [2:0] AddrHeight = {ptr_pkg::RegHeight, 2'b00};

  // Tile rows that fit in one row of tiles.
  localparam int RowsPerTileRow = 8 * ptr_pkg::TilesPerRow;

  // Cycles allowed after the last expected pixel before the block counts as idle.
  localparam int DrainCycles = 10;
  // Several times the length of the slowest correct run.
  localparam int unsigned CycleLimit = 200_000;

  // One input transaction: opcode, palette slot and colour, then the planes from 3 down to 0.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slot;
    logic [23:0] rgb;
    logic [7:0]  p3;
    logic [7:0]  p2;
    logic [7:0]  p1;
    logic [7:0]  p0;
  } tile_item_t;

  // One output transaction.
  typedef struct packed {
    logic [6:0] x;
    logic [8:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_px;
  } pixel_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i      = '0;
  logic [7:0]  entry_index_i = '0;
  logic [23:0] entry_rgb_i   = '0;
  logic [7:0]  plane0_i      = '0;
  logic [7:0]  plane1_i      = '0;
  logic [7:0]  plane2_i      = '0;
  logic [7:0]  plane3_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [6:0]  pixel_x_o;
  logic [8:0]  pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        last_o;

  // Mirror of the block's state and registers, kept in step with accepted transactions.
  logic [23:0] pal_mirror [ptr_pkg::PalDepth];
  int unsigned rows_decoded  = 0;
  logic [7:0]  base_mirror   = 8'd0;
  logic [6:0]  height_mirror = 7'd1;

  // Pixels predicted but not yet seen on the output channel, oldest first.
  pixel_t pending_pixels [$];
  pixel_t oldest_pixel;
  int unsigned fault_count = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;

  planar_tile_row_to_rgb dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .entry_index_i (entry_index_i),
    .entry_rgb_i   (entry_rgb_i),
    .plane0_i      (plane0_i),
    .plane1_i      (plane1_i),
    .plane2_i      (plane2_i),
    .plane3_i      (plane3_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Works out the pixels that one accepted transaction causes and updates the mirror.
  // A decode maps the row counter onto a tile column and an image line; once the
  // counter has passed the last row of tiles, the decode is dropped and the counter
  // holds. The palette slot is an 8-bit sum, so a high base wraps round to entry 0.
  task automatic predict_pixels(input tile_item_t it);
    int unsigned eff_height;
    int unsigned tile_row;
    int unsigned col;
    int unsigned line;
    logic [3:0]  ci;
    logic [7:0]  slot;
    pixel_t      px;
    case (it.op)
      ptr_pkg::OpWritePal: begin
        if (int'(it.slot) < ptr_pkg::PalDepth) pal_mirror[it.slot] = it.rgb;
      end
      ptr_pkg::OpRestart: rows_decoded = 0;
      ptr_pkg::OpDecode: begin
        // A height of zero means one row of tiles; anything above the maximum is clamped.
        eff_height = (height_mirror == 7'd0) ? 1 : int'(height_mirror);
        if (eff_height > ptr_pkg::MaxTileRows) eff_height = ptr_pkg::MaxTileRows;
        tile_row = rows_decoded / RowsPerTileRow;
        if (tile_row < eff_height) begin
          col  = (rows_decoded / 8) % ptr_pkg::TilesPerRow;
          line = tile_row * 8 + rows_decoded % 8;
          for (int k = 0; k < 8; k++) begin
            // Bit 7 of each plane is the leftmost pixel; plane 0 gives the low bit.
            ci   = {it.p3[7 - k], it.p2[7 - k], it.p1[7 - k], it.p0[7 - k]};
            slot = base_mirror + ci;
            px.x = 7'(col * 8 + k);
            px.y = 9'(line);
            {px.red, px.green, px.blue} = pal_mirror[slot % ptr_pkg::PalDepth];
            px.last_px = (k == 7);
            pending_pixels.push_back(px);
          end
          rows_decoded++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Every input transaction is predicted at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_pixels({opcode_i, entry_index_i, entry_rgb_i, plane3_i, plane2_i, plane1_i,
                      plane0_i});
    end
  end

  // The receiver stalls at random, in the proportion set by the running phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Every output transaction is compared with the oldest pixel still expected.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel at x=%0d y=%0d with no pixel expected", pixel_x_o, pixel_y_o);
        fault_count++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        check_field("pixel_x", oldest_pixel.x, pixel_x_o);
        check_field("pixel_y", oldest_pixel.y, pixel_y_o);
        check_field("red", oldest_pixel.red, red_o);
        check_field("green", oldest_pixel.green, green_o);
        check_field("blue", oldest_pixel.blue, blue_o);
        check_field("last", oldest_pixel.last_px, last_o);
      end
    end
  end

  function automatic tile_item_t row_item(input logic [31:0] planes);
    return {ptr_pkg::OpDecode, 8'($urandom), 24'($urandom), planes};
  endfunction

  function automatic tile_item_t pal_item(input logic [7:0] slot, input logic [23:0] rgb);
    return {ptr_pkg::OpWritePal, slot, rgb, 32'($urandom)};
  endfunction

  // Restart and the unused opcode carry random payload, which must not matter.
  function automatic tile_item_t ctl_item(input logic [1:0] op);
    return {op, 8'($urandom), 24'($urandom), 32'($urandom)};
  endfunction

  // Offers one transaction and returns at the edge that accepts it. Valid stays high
  // afterwards so that back-to-back transactions need no gap; wait_idle lowers it.
  task automatic send_item(input tile_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= it.op;
    entry_index_i <= it.slot;
    entry_rgb_i   <= it.rgb;
    plane0_i      <= it.p0;
    plane1_i      <= it.p1;
    plane2_i      <= it.p2;
    plane3_i      <= it.p3;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Returns once every expected pixel has arrived and the block has had time to finish
  // any decode that emits nothing. The first edge lets the last prediction land.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; pready is always high, so the register is
  // written at the end of the access cycle.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrBase) base_mirror = data[7:0];
    else height_mirror = data[6:0];
  endtask

  // The palette holds undefined data after reset. Every base used below (0, 1, 240,
  // 248 and 255) reads a sixteen-entry window that lies within entries 0 to 16 and
  // 240 to 255, so those are written before the first decode.
  task automatic test_palette_fill();
    for (int i = 0; i < 17; i++) send_item(pal_item(8'(i), 24'($urandom)));
    for (int i = 240; i < ptr_pkg::PalDepth; i++) send_item(pal_item(8'(i), 24'($urandom)));
  endtask

  // Plane extremes, each plane on its own, all opcodes and a restart part-way along.
  task automatic test_directed_rows();
    wait_idle();
    reg_write(AddrBase, 32'd0);
    reg_write(AddrHeight, 32'd1);
    send_item(pal_item(8'h00, 24'h000000));
    send_item(pal_item(8'h0F, 24'hFFFFFF));
    send_item(pal_item(8'hFF, 24'h5AC3A5));
    send_item(ctl_item(ptr_pkg::OpRestart));
    send_item(row_item(32'h0000_0000));
    send_item(row_item(32'hFFFF_FFFF));
    send_item(row_item(32'h0000_00FF));
    send_item(row_item(32'h0000_FF00));
    send_item(row_item(32'h00FF_0000));
    send_item(row_item(32'hFF00_0000));
    send_item(row_item(32'hAA55_AA55));
    send_item(row_item(32'h8040_2010));
    send_item(ctl_item(OpUnused));
    send_item(row_item(32'($urandom)));
    send_item(ctl_item(ptr_pkg::OpRestart));
    send_item(row_item(32'($urandom)));
    wait_idle();
  endtask

  // Base 255 makes the palette slot wrap past entry 255; bases 240 and 1 are also run.
  task automatic test_index_wrap();
    logic [7:0] bases [3];
    bases = '{8'd255, 8'd240, 8'd1};
    foreach (bases[i]) begin
      reg_write(AddrBase, {24'd0, bases[i]});
      send_item(row_item(32'hFFFF_FFFF));
      send_item(row_item(32'h0000_0000));
      send_item(row_item(32'($urandom)));
      wait_idle();
    end
  endtask

  // Fills the whole image and then sends a few more rows, which must be dropped,
  // before a restart brings the counter back to the top-left tile.
  task automatic test_image_end(input logic [6:0] height, input int unsigned tile_rows);
    reg_write(AddrHeight, {25'd0, height});
    send_item(ctl_item(ptr_pkg::OpRestart));
    repeat (tile_rows * RowsPerTileRow + 3) send_item(row_item(32'($urandom)));
    send_item(ctl_item(ptr_pkg::OpRestart));
    send_item(row_item(32'($urandom)));
    wait_idle();
  endtask

  // Random transactions under a random setting: mostly decodes from a fresh image,
  // with palette rewrites, restarts and the unused opcode mixed in.
  task automatic test_random(input int unsigned count);
    int unsigned pick;
    logic [7:0]  base;
    logic [6:0]  height;
    case ($urandom_range(0, 4))
      0: base = 8'd0;
      1: base = 8'd1;
      2: base = 8'd240;
      3: base = 8'd248;
      default: base = 8'd255;
    endcase
    case ($urandom_range(0, 3))
      0: height = 7'd1;
      1: height = 7'd2;
      2: height = 7'(ptr_pkg::MaxTileRows);
      default: height = 7'($urandom);
    endcase
    reg_write(AddrBase, {24'd0, base});
    reg_write(AddrHeight, {25'd0, height});
    send_item(ctl_item(ptr_pkg::OpRestart));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) send_item(row_item(32'($urandom)));
      else if (pick < 90) send_item(pal_item(8'($urandom), 24'($urandom)));
      else if (pick < 95) send_item(ctl_item(ptr_pkg::OpRestart));
      else send_item(ctl_item(OpUnused));
    end
    wait_idle();
  endtask

  // Ends the run if the block stops making progress.
  initial begin
    for (int unsigned n = 0; n < CycleLimit; n++) @(posedge clk_i);
    $display("[planar_tile_row_to_rgb] ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The sender idles rarely while the receiver stalls often.
    in_idle_pct   = 19;
    out_stall_pct = 76;
    test_palette_fill();
    test_directed_rows();
    test_index_wrap();
    test_image_end(7'd0, 1);
    test_random(18);
    test_random(18);

    // The other way round.
    in_idle_pct   = 76;
    out_stall_pct = 19;
    test_random(18);
    test_random(18);

    // Full rate on both sides.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    test_random(18);
    test_random(18);

    wait_idle();
    if (fault_count == 0) begin
      $display("[planar_tile_row_to_rgb] OK");
    end else begin
      $display("[planar_tile_row_to_rgb] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ptr_pkg.sv
hw/rtl/planar_tile_row_to_rgb.sv
hw/rtl/ptr_checker.sv
tb/sv/tb.sv
